// File: sv/c2cyl_pkg.sv
// ============================================================================
// c2cyl_pkg: shared types, widths and constant tables
// Request and response formats, pipeline depths, CORDIC arctangent table and
// the radians-to-degrees factor, all worked out at elaboration.
// ============================================================================
package c2cyl_pkg;

    localparam int C_COORD_WIDTH = 24;
    localparam int C_PHI_WIDTH   = 25;
    localparam int C_FRAC_DEG    = 16;

    // angle path
    localparam int C_NORM_WIDTH  = 61;     // folded magnitude lands in [2^60, 2^61)
    localparam int C_NORM_STAGES = 3;
    localparam int C_VEC_WIDTH   = 64;
    localparam int C_Z_WIDTH     = 35;     // radians Q32, signed
    localparam int C_ZC_WIDTH    = 32;
    localparam int C_DEG_K_WIDTH = 30;
    localparam int C_PROD_WIDTH  = C_ZC_WIDTH + C_DEG_K_WIDTH;
    localparam int C_ANG_WIDTH   = 23;
    localparam int C_STEPS       = 34;
    localparam int C_DEG_STAGES  = 3;

    // latency after the fold register, both paths line up on this
    localparam int C_PHI_LAT     = C_NORM_STAGES + C_STEPS + C_DEG_STAGES;

    // radius path
    localparam int C_SQ_WIDTH      = 2 * C_COORD_WIDTH + 2;
    localparam int C_ROOT_STEPS    = C_COORD_WIDTH + 1;
    localparam int C_SQRT_CORE_LAT = C_ROOT_STEPS + 3;
    localparam int C_SQRT_PAD      = C_PHI_LAT - C_SQRT_CORE_LAT;

    localparam logic [63:0] C_PI_Q60 = 64'h3243F6A8885A308D;

    typedef struct packed {
        logic signed [C_COORD_WIDTH-1:0] x_pos;
        logic signed [C_COORD_WIDTH-1:0] y_pos;
    } t_in_req;

    typedef struct packed {
        logic [C_PHI_WIDTH-1:0]   phi_deg;
        logic [C_COORD_WIDTH-1:0] rho_len;
    } t_out_req;

    // octant bookkeeping that rides along with the angle
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic swap;
        logic origin;
    } t_oct;

    // restoring divide, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        int          b;
        rem = '0;
        q   = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q32: series in Q62 with truncated terms, rounded half up
    function automatic logic [C_ZC_WIDTH-1:0] f_atan(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        acc = '0;
        if (i == 0) begin
            sum = C_PI_Q60 + (64'd1 << 29);
        end else begin
            for (k = 0; k < 32; k++) begin
                if (i * (2 * k + 1) < 62) begin
                    term = f_udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                    if ((k & 1) == 0) begin
                        acc = acc + term;
                    end else begin
                        acc = acc - term;
                    end
                end
            end
            sum = acc + (64'd1 << 29);
        end
        return sum[61:30];
    endfunction

    // round(180/pi * 2^24)
    function automatic logic [C_DEG_K_WIDTH-1:0] f_deg_k();
        logic [63:0] r;
        logic [63:0] q;
        int          n;
        r = 64'd180;
        q = '0;
        for (n = 0; n < 84; n++) begin
            r = r << 1;
            q = q << 1;
            if (r >= C_PI_Q60) begin
                r = r - C_PI_Q60;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= C_PI_Q60) begin
            q = q + 64'd1;
        end
        return q[C_DEG_K_WIDTH-1:0];
    endfunction

    localparam logic [C_DEG_K_WIDTH-1:0] C_DEG_K = f_deg_k();

endpackage

// File: sv/c2cyl_fold.sv
// ============================================================================
// c2cyl_fold: octant fold and normalization
// Takes absolute values, orders the pair so the larger leads, then shifts
// both left until the larger has its top bit at position 60.
// ============================================================================
module c2cyl_fold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  c2cyl_pkg::t_in_req                     i_req,
    output logic                                   o_vld,
    output logic [c2cyl_pkg::C_NORM_WIDTH-1:0]     o_big,
    output logic [c2cyl_pkg::C_NORM_WIDTH-1:0]     o_small,
    output c2cyl_pkg::t_oct                        o_oct,
    output logic [c2cyl_pkg::C_COORD_WIDTH-1:0]    o_ax,
    output logic [c2cyl_pkg::C_COORD_WIDTH-1:0]    o_ay
);

    localparam int W   = c2cyl_pkg::C_COORD_WIDTH;
    localparam int NW  = c2cyl_pkg::C_NORM_WIDTH;
    localparam int NS  = c2cyl_pkg::C_NORM_STAGES;
    localparam int TOP = NW - 1;

    // ---- fold register ----
    logic [W-1:0]     n_ax, n_ay, n_big, n_small;
    c2cyl_pkg::t_oct  n_oct;

    logic             r_a_vld;
    logic [W-1:0]     r_ax, r_ay, r_big, r_small;
    c2cyl_pkg::t_oct  r_a_oct;

    always_comb begin
        n_ax = i_req.x_pos[W-1] ? (~i_req.x_pos) + W'(1) : i_req.x_pos;
        n_ay = i_req.y_pos[W-1] ? (~i_req.y_pos) + W'(1) : i_req.y_pos;
        n_oct.x_neg  = i_req.x_pos[W-1];
        n_oct.y_neg  = i_req.y_pos[W-1];
        n_oct.swap   = (n_ax < n_ay);
        n_oct.origin = (n_ax == '0) && (n_ay == '0);
        n_big   = n_oct.swap ? n_ay : n_ax;
        n_small = n_oct.swap ? n_ax : n_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_big   <= n_big;
            r_small <= n_small;
            r_a_oct <= n_oct;
        end
    end

    // ---- normalize: two shift steps per stage (32/16, 8/4, 2/1) ----
    logic             r_vld   [NS];
    logic [NW-1:0]    r_na    [NS];
    logic [NW-1:0]    r_nb    [NS];
    c2cyl_pkg::t_oct  r_oct   [NS];

    for (genvar gs = 0; gs < NS; gs++) begin : g_norm
        localparam int SH_HI = 32 >> (2 * gs);
        localparam int SH_LO = SH_HI >> 1;

        logic            s_vld;
        logic [NW-1:0]   s_a, s_b, n_a, n_b;
        c2cyl_pkg::t_oct s_oct;

        if (gs == 0) begin : g_head
            assign s_vld = r_a_vld;
            assign s_a   = NW'(r_big);
            assign s_b   = NW'(r_small);
            assign s_oct = r_a_oct;
        end else begin : g_tail
            assign s_vld = r_vld[gs-1];
            assign s_a   = r_na[gs-1];
            assign s_b   = r_nb[gs-1];
            assign s_oct = r_oct[gs-1];
        end

        always_comb begin
            n_a = s_a;
            n_b = s_b;
            if (n_a[TOP -: SH_HI] == '0) begin
                n_a = n_a << SH_HI;
                n_b = n_b << SH_HI;
            end
            if (n_a[TOP -: SH_LO] == '0) begin
                n_a = n_a << SH_LO;
                n_b = n_b << SH_LO;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_na[gs]  <= n_a;
                r_nb[gs]  <= n_b;
                r_oct[gs] <= s_oct;
            end
        end
    end

    assign o_vld   = r_vld[NS-1];
    assign o_big   = r_na[NS-1];
    assign o_small = r_nb[NS-1];
    assign o_oct   = r_oct[NS-1];
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;

endmodule

// File: sv/c2cyl_cordic.sv
// ============================================================================
// c2cyl_cordic: vectoring CORDIC, one rotation per stage
// Drives y toward zero and sums the rotation angles in Q32 radians.
// ============================================================================
module c2cyl_cordic (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_vld,
    input  logic [c2cyl_pkg::C_NORM_WIDTH-1:0]        i_big,
    input  logic [c2cyl_pkg::C_NORM_WIDTH-1:0]        i_small,
    input  c2cyl_pkg::t_oct                           i_oct,
    output logic                                      o_vld,
    output logic signed [c2cyl_pkg::C_Z_WIDTH-1:0]    o_z,
    output c2cyl_pkg::t_oct                           o_oct
);

    localparam int VW    = c2cyl_pkg::C_VEC_WIDTH;
    localparam int ZW    = c2cyl_pkg::C_Z_WIDTH;
    localparam int ZCW   = c2cyl_pkg::C_ZC_WIDTH;
    localparam int STEPS = c2cyl_pkg::C_STEPS;

    logic                  r_vld [STEPS];
    logic signed [VW-1:0]  r_x   [STEPS];
    logic signed [VW-1:0]  r_y   [STEPS];
    logic signed [ZW-1:0]  r_z   [STEPS];
    c2cyl_pkg::t_oct       r_oct [STEPS];

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
        localparam logic [ZCW-1:0]       LP_ATAN = c2cyl_pkg::f_atan(gi);
        localparam logic signed [ZW-1:0] LP_DZ   = $signed(ZW'(LP_ATAN));

        logic                 s_vld;
        logic signed [VW-1:0] s_x, s_y, n_x, n_y;
        logic signed [ZW-1:0] s_z, n_z;
        c2cyl_pkg::t_oct      s_oct;

        if (gi == 0) begin : g_head
            assign s_vld = i_vld;
            assign s_x   = $signed(VW'(i_big));
            assign s_y   = $signed(VW'(i_small));
            assign s_z   = '0;
            assign s_oct = i_oct;
        end else begin : g_tail
            assign s_vld = r_vld[gi-1];
            assign s_x   = r_x[gi-1];
            assign s_y   = r_y[gi-1];
            assign s_z   = r_z[gi-1];
            assign s_oct = r_oct[gi-1];
        end

        // arithmetic shift of y rounds toward minus infinity
        always_comb begin
            if (!s_y[VW-1]) begin
                n_x = s_x + (s_y >>> gi);
                n_y = s_y - (s_x >>> gi);
                n_z = s_z + LP_DZ;
            end else begin
                n_x = s_x - (s_y >>> gi);
                n_y = s_y + (s_x >>> gi);
                n_z = s_z - LP_DZ;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[gi]   <= n_x;
                r_y[gi]   <= n_y;
                r_z[gi]   <= n_z;
                r_oct[gi] <= s_oct;
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_z   = r_z[STEPS-1];
    assign o_oct = r_oct[STEPS-1];

endmodule

// File: sv/c2cyl_deg.sv
// ============================================================================
// c2cyl_deg: radians to degrees and octant unfold
// Scales the first-octant angle to degrees Q16, then maps it back to the
// point's quadrant and wraps into [0, 360).
// ============================================================================
module c2cyl_deg (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_vld,
    input  logic signed [c2cyl_pkg::C_Z_WIDTH-1:0]    i_z,
    input  c2cyl_pkg::t_oct                           i_oct,
    output logic                                      o_vld,
    output logic [c2cyl_pkg::C_PHI_WIDTH-1:0]         o_phi
);

    localparam int ZW   = c2cyl_pkg::C_Z_WIDTH;
    localparam int ZCW  = c2cyl_pkg::C_ZC_WIDTH;
    localparam int PW   = c2cyl_pkg::C_PROD_WIDTH;
    localparam int AW   = c2cyl_pkg::C_ANG_WIDTH;
    localparam int PHW  = c2cyl_pkg::C_PHI_WIDTH;
    localparam int FD   = c2cyl_pkg::C_FRAC_DEG;
    localparam int RSH  = 40;

    localparam logic [AW-1:0]  LP_DEG90  = AW'(90 << FD);
    localparam logic [PHW-1:0] LP_DEG180 = PHW'(180 << FD);
    localparam logic [PHW-1:0] LP_DEG360 = PHW'(360 << FD);
    localparam logic [PW:0]    LP_HALF   = (PW + 1)'(1) << (RSH - 1);

    // ---- multiply ----
    logic [ZCW-1:0]   n_zc;
    logic             r_m_vld;
    logic [PW-1:0]    r_m_prod;
    c2cyl_pkg::t_oct  r_m_oct;

    assign n_zc = i_z[ZW-1] ? '0 : i_z[ZCW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (i_en) begin
            r_m_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_prod <= PW'(n_zc) * PW'(c2cyl_pkg::C_DEG_K);
            r_m_oct  <= i_oct;
        end
    end

    // ---- round, undo the x/y swap ----
    logic [PW:0]      n_sum;
    logic [AW-1:0]    n_ang, n_t;
    logic             r_f_vld;
    logic [AW-1:0]    r_f_t;
    c2cyl_pkg::t_oct  r_f_oct;

    always_comb begin
        n_sum = {1'b0, r_m_prod} + LP_HALF;
        n_ang = n_sum[RSH +: AW];
        n_t   = r_m_oct.swap ? LP_DEG90 - n_ang : n_ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_t   <= n_t;
            r_f_oct <= r_m_oct;
        end
    end

    // ---- quadrant and wrap ----
    logic [PHW-1:0] n_t_ext, n_quad, n_phi;
    logic           r_o_vld;
    logic [PHW-1:0] r_o_phi;

    always_comb begin
        n_t_ext = PHW'(r_f_t);
        if (!r_f_oct.x_neg && !r_f_oct.y_neg) begin
            n_quad = n_t_ext;
        end else if (r_f_oct.x_neg && !r_f_oct.y_neg) begin
            n_quad = LP_DEG180 - n_t_ext;
        end else if (r_f_oct.x_neg) begin
            n_quad = LP_DEG180 + n_t_ext;
        end else begin
            n_quad = LP_DEG360 - n_t_ext;
        end
        if (r_f_oct.origin) begin
            n_phi = '0;
        end else if (n_quad >= LP_DEG360) begin
            n_phi = n_quad - LP_DEG360;
        end else begin
            n_phi = n_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_phi <= n_phi;
        end
    end

    assign o_vld = r_o_vld;
    assign o_phi = r_o_phi;

    a_phi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_phi < LP_DEG360))
        else $error("azimuth out of [0, 360)");

endmodule

// File: sv/c2cyl_sqrt.sv
// ============================================================================
// c2cyl_sqrt: radius pipeline
// Squares and sum, a digit-by-digit square root with one result bit per
// stage, round to nearest, then delay to line up with the angle path.
// ============================================================================
module c2cyl_sqrt (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [c2cyl_pkg::C_COORD_WIDTH-1:0]   i_ax,
    input  logic [c2cyl_pkg::C_COORD_WIDTH-1:0]   i_ay,
    output logic [c2cyl_pkg::C_COORD_WIDTH-1:0]   o_rho
);

    localparam int W   = c2cyl_pkg::C_COORD_WIDTH;
    localparam int PW  = 2 * W;
    localparam int SW  = c2cyl_pkg::C_SQ_WIDTH;
    localparam int NR  = c2cyl_pkg::C_ROOT_STEPS;
    localparam int PAD = c2cyl_pkg::C_SQRT_PAD;

    logic [PW-1:0] r_sqx, r_sqy;
    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= PW'(i_ax) * PW'(i_ax);
            r_sqy <= PW'(i_ay) * PW'(i_ay);
            r_sum <= SW'(r_sqx) + SW'(r_sqy);
        end
    end

    logic [SW-1:0] r_rem [NR];
    logic [SW-1:0] r_res [NR];

    for (genvar gm = 0; gm < NR; gm++) begin : g_root
        localparam logic [SW-1:0] LP_BIT = SW'(1) << (2 * (NR - 1 - gm));

        logic [SW-1:0] s_rem, s_res, n_rem, n_res;
        logic [SW:0]   n_trial;

        if (gm == 0) begin : g_head
            assign s_rem = r_sum;
            assign s_res = '0;
        end else begin : g_tail
            assign s_rem = r_rem[gm-1];
            assign s_res = r_res[gm-1];
        end

        always_comb begin
            n_trial = {1'b0, s_res} + {1'b0, LP_BIT};
            if ({1'b0, s_rem} >= n_trial) begin
                n_rem = s_rem - n_trial[SW-1:0];
                n_res = (s_res >> 1) + LP_BIT;
            end else begin
                n_rem = s_rem;
                n_res = s_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gm] <= n_rem;
                r_res[gm] <= n_res;
            end
        end
    end

    // remainder is n - root^2; round up when it exceeds root
    logic [W-1:0] r_rnd;
    logic [W-1:0] r_pad [PAD];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd <= (r_rem[NR-1] > r_res[NR-1]) ? r_res[NR-1][W-1:0] + W'(1)
                                                 : r_res[NR-1][W-1:0];
        end
    end

    for (genvar gp = 0; gp < PAD; gp++) begin : g_pad
        if (gp == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pad[gp] <= r_rnd;
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pad[gp] <= r_pad[gp-1];
                end
            end
        end
    end

    assign o_rho = r_pad[PAD-1];

endmodule

// File: sv/c2cyl_obuf.sv
// ============================================================================
// c2cyl_obuf: two-entry output buffer
// Holds finished results for the consumer; reports space from registered
// state only, so the pipeline keeps moving while one result waits.
// ============================================================================
module c2cyl_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  c2cyl_pkg::t_out_req  i_wdata,
    output logic                 o_space,
    output logic                 o_vld,
    output c2cyl_pkg::t_out_req  o_rdata,
    input  logic                 i_rdy
);

    localparam logic [1:0] LP_EMPTY = 2'd0;
    localparam logic [1:0] LP_FULL  = 2'd2;

    c2cyl_pkg::t_out_req r_mem [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt, n_cnt;
    logic                w_rd;

    assign w_rd = o_vld && i_rdy;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_wr && w_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= LP_EMPTY;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_space = (r_cnt != LP_FULL);
    assign o_vld   = (r_cnt != LP_EMPTY);
    assign o_rdata = r_mem[r_rp];

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_cnt != LP_FULL))
        else $error("write into full output buffer");

endmodule

// File: sv/cartesian_to_cylindrical_core.sv
// ============================================================================
// cartesian_to_cylindrical_core: (x, y) to azimuth and radius
// Accepts one point per clock unless paused; gives phi in degrees Q16 and rho.
// ============================================================================
// Takes one request per clock cycle unless paused and returns the results in
// order. The depth comes from the angle path: a fold register,
// three normalization stages, the 34 stages of the vectoring CORDIC and three
// stages of degree scaling and quadrant fix-up. The radius (squares, one root
// bit per stage, rounding) runs alongside and is delay-matched to it. A
// two-entry output buffer keeps input ready high while one result waits; the
// whole pipeline pauses only when both entries are full.
module cartesian_to_cylindrical_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  c2cyl_pkg::t_in_req   i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output c2cyl_pkg::t_out_req  o_out_req
);

    localparam int W   = c2cyl_pkg::C_COORD_WIDTH;
    localparam int NW  = c2cyl_pkg::C_NORM_WIDTH;
    localparam int ZW  = c2cyl_pkg::C_Z_WIDTH;
    localparam int PHW = c2cyl_pkg::C_PHI_WIDTH;

    logic                  w_en;
    logic                  w_fold_vld;
    logic [NW-1:0]         w_big, w_small;
    c2cyl_pkg::t_oct       w_fold_oct;
    logic [W-1:0]          w_ax, w_ay;
    logic                  w_cor_vld;
    logic signed [ZW-1:0]  w_z;
    c2cyl_pkg::t_oct       w_cor_oct;
    logic                  w_phi_vld;
    logic [PHW-1:0]        w_phi;
    logic [W-1:0]          w_rho;
    c2cyl_pkg::t_out_req   w_rsp;

    c2cyl_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_req   (i_in_req),
        .o_vld   (w_fold_vld),
        .o_big   (w_big),
        .o_small (w_small),
        .o_oct   (w_fold_oct),
        .o_ax    (w_ax),
        .o_ay    (w_ay)
    );

    c2cyl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fold_vld),
        .i_big   (w_big),
        .i_small (w_small),
        .i_oct   (w_fold_oct),
        .o_vld   (w_cor_vld),
        .o_z     (w_z),
        .o_oct   (w_cor_oct)
    );

    c2cyl_deg u_deg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_cor_vld),
        .i_z     (w_z),
        .i_oct   (w_cor_oct),
        .o_vld   (w_phi_vld),
        .o_phi   (w_phi)
    );

    c2cyl_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ax  (w_ax),
        .i_ay  (w_ay),
        .o_rho (w_rho)
    );

    always_comb begin
        w_rsp.phi_deg = w_phi;
        w_rsp.rho_len = w_rho;
    end

    c2cyl_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_en && w_phi_vld),
        .i_wdata (w_rsp),
        .o_space (w_en),
        .o_vld   (o_out_valid),
        .o_rdata (o_out_req),
        .i_rdy   (i_out_ready)
    );

    assign o_in_ready = w_en;

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(w_phi_vld) && $stable(w_phi) && $stable(w_rho)))
        else $error("pipeline moved while paused");

    a_pause_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without a waiting result");

endmodule
